// File: rtl/ati_pkg.sv
package ati_pkg;

  localparam int ADC_W        = 12;
  localparam int TEMP_W       = 16;
  localparam int SCALE_W      = 16;
  localparam int OPC_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int POS_W        = ADC_W + SCALE_W;
  localparam int FRAC_W       = 16;

  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 32;
  localparam int TUSER_W      = 2;

  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [ADC_W-1:0]   ADC_MAX          = 12'd4095;
  localparam logic [ADC_W-1:0]   MIN_ADC_RST      = 12'd300;
  localparam logic [SCALE_W-1:0] SCALE_K_RST      = 16'd925;
  localparam logic [TEMP_W-1:0]  MAX_TEMP_RST     = 16'd4000;

  localparam int RESET_DEG_START = 200;
  localparam int RESET_DEG_STEP  = 25;
  localparam int TEMP_UNITS      = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ADC  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_K  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TEMP = 2'd2;

  localparam logic [OPC_W-1:0] OP_CONVERT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_CAL_START = 2'd1;
  localparam logic [OPC_W-1:0] OP_CAL_PUSH  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CONV = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic              below;
    logic [ADC_W-1:0]  diff;
    logic [TEMP_W-1:0] temp;
  } cmd_t;

  function automatic logic [TEMP_W-1:0] reset_temp(int idx);
    int deg;
    deg = RESET_DEG_START - RESET_DEG_STEP * idx;
    if (deg > 0) begin
      return TEMP_W'(deg * TEMP_UNITS);
    end
    return '0;
  endfunction

endpackage

// File: rtl/adc_temperature_interpolator.sv
// Converts 12-bit ADC samples to temperature in 1/16 degree units through a
// small table with linear interpolation, and runs a calibration sequence that
// refills the table from its last entry down.
// Input words carry the opcode in in_tuser and the sample and calibration
// temperature in in_tdata. Every input word yields exactly one output word,
// in order, with the status in out_tuser and the temperature and required
// ADC value in out_tdata. Registers are written through cfg_we, cfg_addr and
// cfg_wdata; the user must write them only while no word is in flight, as
// the block does not enforce it. An input word passes an input register
// and a two-word queue, then the execution unit. A convert below min_adc
// returns max_temp, one past the table returns the last entry and any other
// interpolates between two entries; a calibration word that computes a new
// required ADC value uses the bit-serial divider. One word is executed at a
// time, while the input register and queue go on taking further words.
// Reset restores the register defaults, the factory temperature curve and
// the not-initialized calibration state, and empties the queue.
// When the receiver stalls, the output word holds; the execution unit waits
// with its next result, and the input side keeps taking words until the
// queue and input register are full.
module adc_temperature_interpolator #(
  parameter int TABLE_ENTRIES = ati_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // adc_sample [11:0], cal_temperature [27:12], zeros above.
  input  logic [ati_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode [1:0].
  input  logic [ati_pkg::TUSER_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // temperature [15:0], required_adc [27:16], zeros above.
  output logic [ati_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // cal_status [1:0].
  output logic [ati_pkg::TUSER_W-1:0]        out_tuser,
  input  logic                               cfg_we,
  input  logic [ati_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ati_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = ati_pkg::ADC_W;
  localparam int TW = ati_pkg::TEMP_W;

  logic [AW-1:0]                  min_adc_r;
  logic [AW-1:0]                  min_adc_nxt;
  logic [ati_pkg::SCALE_W-1:0]    scale_k_r;
  logic [ati_pkg::SCALE_W-1:0]    scale_k_nxt;
  logic [TW-1:0]                  max_temp_r;
  logic [TW-1:0]                  max_temp_nxt;

  logic                           q_push;
  logic                           q_full;
  ati_pkg::cmd_t                  front_cmd;
  logic                           q_pop;
  logic                           q_valid;
  ati_pkg::cmd_t                  q_head;
  logic [TW-1:0]                  res_temp;
  logic [ati_pkg::STATUS_W-1:0]   res_status;
  logic [AW-1:0]                  res_req;

  always_comb begin
    min_adc_nxt  = min_adc_r;
    scale_k_nxt  = scale_k_r;
    max_temp_nxt = max_temp_r;
    if (cfg_we) begin
      case (cfg_addr)
        ati_pkg::REG_MIN_ADC:  min_adc_nxt  = cfg_wdata[AW-1:0];
        ati_pkg::REG_SCALE_K:  scale_k_nxt  = cfg_wdata;
        ati_pkg::REG_MAX_TEMP: max_temp_nxt = cfg_wdata;
        default: begin
          min_adc_nxt = min_adc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_adc_r  <= ati_pkg::MIN_ADC_RST;
      scale_k_r  <= ati_pkg::SCALE_K_RST;
      max_temp_r <= ati_pkg::MAX_TEMP_RST;
    end else begin
      min_adc_r  <= min_adc_nxt;
      scale_k_r  <= scale_k_nxt;
      max_temp_r <= max_temp_nxt;
    end
  end

  ati_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .opcode          (in_tuser),
    .adc_sample      (in_tdata[AW-1:0]),
    .cal_temperature (in_tdata[AW +: TW]),
    .min_adc         (min_adc_r),
    .push            (q_push),
    .q_full          (q_full),
    .cmd             (front_cmd)
  );

  ati_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  ati_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (q_valid),
    .cmd_head     (q_head),
    .cmd_pop      (q_pop),
    .min_adc      (min_adc_r),
    .scale_k      (scale_k_r),
    .temp_limit   (max_temp_r),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .temperature  (res_temp),
    .cal_status   (res_status),
    .required_adc (res_req)
  );

  assign out_tdata = {{(ati_pkg::OUT_TDATA_W - TW - AW){1'b0}}, res_req, res_temp};
  assign out_tuser = res_status;

endmodule

// File: rtl/ati_front.sv
module ati_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ati_pkg::OPC_W-1:0]     opcode,
  input  logic [ati_pkg::ADC_W-1:0]     adc_sample,
  input  logic [ati_pkg::TEMP_W-1:0]    cal_temperature,
  input  logic [ati_pkg::ADC_W-1:0]     min_adc,
  output logic                          push,
  input  logic                          q_full,
  output ati_pkg::cmd_t                 cmd
);

  logic          valid_r;
  logic          valid_nxt;
  ati_pkg::cmd_t cmd_r;
  ati_pkg::cmd_t cmd_nxt;
  logic          take;

  assign in_ready = !valid_r || !q_full;
  assign take     = in_valid && in_ready;
  assign push     = valid_r && !q_full;
  assign cmd      = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt      = 1'b1;
      cmd_nxt.opcode = opcode;
      cmd_nxt.below  = adc_sample < min_adc;
      cmd_nxt.diff   = adc_sample - min_adc;
      cmd_nxt.temp   = cal_temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// File: rtl/ati_queue.sv
module ati_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ati_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ati_pkg::cmd_t head
);

  localparam int DEPTH = ati_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ati_pkg::cmd_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/ati_div.sv
module ati_div #(
  parameter int DW = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DW-1:0]                  dividend,
  input  logic [ati_pkg::SCALE_W-1:0]    divisor,
  output logic                           done,
  output logic [DW-1:0]                  quotient
);

  localparam int SW    = ati_pkg::SCALE_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             busy_nxt;
  logic             done_r;
  logic             done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [DW-1:0]    num_r;
  logic [DW-1:0]    num_nxt;
  logic [DW-1:0]    quo_r;
  logic [DW-1:0]    quo_nxt;
  logic [SW-1:0]    rem_r;
  logic [SW-1:0]    rem_nxt;
  logic [SW-1:0]    div_r;
  logic [SW-1:0]    div_nxt;
  logic [SW:0]      trial;
  logic [SW:0]      trial_sub;
  logic             fits;

  assign trial     = {rem_r, num_r[DW-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign fits      = trial >= {1'b0, div_r};
  assign done      = done_r;
  assign quotient  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      num_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[DW-2:0], 1'b0};
      quo_nxt = {quo_r[DW-2:0], fits};
      rem_nxt = fits ? trial_sub[SW-1:0] : trial[SW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule

// File: rtl/ati_back.sv
module ati_back #(
  parameter int TABLE_ENTRIES = ati_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  ati_pkg::cmd_t                   cmd_head,
  output logic                            cmd_pop,
  input  logic [ati_pkg::ADC_W-1:0]       min_adc,
  input  logic [ati_pkg::SCALE_W-1:0]     scale_k,
  input  logic [ati_pkg::TEMP_W-1:0]      temp_limit,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [ati_pkg::TEMP_W-1:0]      temperature,
  output logic [ati_pkg::STATUS_W-1:0]    cal_status,
  output logic [ati_pkg::ADC_W-1:0]       required_adc
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DW     = IDX_W + ati_pkg::SCALE_W;
  localparam int TW     = ati_pkg::TEMP_W;
  localparam int AW     = ati_pkg::ADC_W;
  localparam int SW     = ati_pkg::STATUS_W;
  localparam int PW     = ati_pkg::POS_W;
  localparam int FW     = ati_pkg::FRAC_W;
  localparam int PROD_W = 2 * (TW + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FW - 1));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POS  = 4'd1;
  localparam logic [3:0] S_SEG  = 4'd2;
  localparam logic [3:0] S_LO   = 4'd3;
  localparam logic [3:0] S_HI   = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_LAST = 4'd6;
  localparam logic [3:0] S_REQ  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]               state_r;
  logic [3:0]               state_nxt;
  ati_pkg::cmd_t            cmd_r;
  ati_pkg::cmd_t            cmd_nxt;
  logic [PW-1:0]            pos_r;
  logic [PW-1:0]            pos_nxt;
  logic [IDX_W-1:0]         seg_r;
  logic [IDX_W-1:0]         seg_nxt;
  logic [TW-1:0]            lo_r;
  logic [TW-1:0]            lo_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [TW-1:0]            res_temp_r;
  logic [TW-1:0]            res_temp_nxt;
  logic [SW-1:0]            res_status_r;
  logic [SW-1:0]            res_status_nxt;
  logic [SW-1:0]            phase_r;
  logic [SW-1:0]            phase_nxt;
  logic [IDX_W-1:0]         cal_idx_r;
  logic [IDX_W-1:0]         cal_idx_nxt;
  logic [AW-1:0]            req_r;
  logic [AW-1:0]            req_nxt;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [TW-1:0]            out_temp_r;
  logic [SW-1:0]            out_status_r;
  logic [AW-1:0]            out_req_r;
  logic                     out_load;

  logic [TW-1:0]            mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] written_r;
  logic [TW-1:0]            rd_data_r;
  logic                     rd_written_r;
  logic [IDX_W-1:0]         rd_addr_r;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [TW-1:0]            table_rd;

  logic                     div_start;
  logic [DW-1:0]            div_dividend;
  logic                     div_done;
  logic [DW-1:0]            div_quo;
  logic [DW:0]              req_sum;
  logic [AW-1:0]            req_sat;

  logic signed [TW:0]       step_diff;
  logic signed [TW:0]       frac_s;
  logic signed [PROD_W-1:0] acc;

  assign table_rd  = rd_written_r ? rd_data_r : ati_pkg::reset_temp(int'(rd_addr_r));
  assign step_diff = $signed({1'b0, table_rd}) - $signed({1'b0, lo_r});
  assign frac_s    = $signed({1'b0, pos_r[FW-1:0]});
  assign acc       = $signed({2'b00, lo_r, {FW{1'b0}}}) + prod_r + ROUND_HALF;

  assign div_dividend = {cal_idx_r, {ati_pkg::SCALE_W{1'b0}}} + DW'(scale_k >> 1);
  assign req_sum      = (DW+1)'(min_adc) + (DW+1)'(div_quo);
  assign req_sat      = (req_sum > (DW+1)'(ati_pkg::ADC_MAX)) ? ati_pkg::ADC_MAX
                                                              : req_sum[AW-1:0];

  ati_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (scale_k),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    seg_nxt        = seg_r;
    lo_nxt         = lo_r;
    prod_nxt       = prod_r;
    res_temp_nxt   = res_temp_r;
    res_status_nxt = res_status_r;
    phase_nxt      = phase_r;
    cal_idx_nxt    = cal_idx_r;
    req_nxt        = req_r;
    rd_en          = 1'b0;
    rd_addr        = seg_r;
    wr_en          = 1'b0;
    div_start      = 1'b0;
    cmd_pop        = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd_head;
          res_temp_nxt   = '0;
          res_status_nxt = phase_r;
          state_nxt      = S_OUT;
          case (cmd_head.opcode)
            ati_pkg::OP_CONVERT: begin
              res_status_nxt = ati_pkg::ST_CONV;
              if (cmd_head.below) begin
                res_temp_nxt = temp_limit;
              end else begin
                state_nxt = S_POS;
              end
            end
            ati_pkg::OP_CAL_START: begin
              cal_idx_nxt    = LAST;
              phase_nxt      = ati_pkg::ST_WAIT;
              res_status_nxt = ati_pkg::ST_WAIT;
              state_nxt      = S_REQ;
            end
            ati_pkg::OP_CAL_PUSH: begin
              if (phase_r == ati_pkg::ST_WAIT) begin
                wr_en = 1'b1;
                if (cmd_head.temp >= temp_limit || cal_idx_r == '0) begin
                  phase_nxt      = ati_pkg::ST_DONE;
                  res_status_nxt = ati_pkg::ST_DONE;
                end else begin
                  cal_idx_nxt    = cal_idx_r - 1'b1;
                  res_status_nxt = ati_pkg::ST_WAIT;
                  state_nxt      = S_REQ;
                end
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_POS: begin
        pos_nxt   = cmd_r.diff * scale_k;
        state_nxt = S_SEG;
      end
      S_SEG: begin
        rd_en = 1'b1;
        if (pos_r[PW-1:FW] >= AW'(TABLE_ENTRIES - 1)) begin
          rd_addr   = LAST;
          state_nxt = S_LAST;
        end else begin
          seg_nxt   = pos_r[FW +: IDX_W];
          rd_addr   = pos_r[FW +: IDX_W];
          state_nxt = S_LO;
        end
      end
      S_LAST: begin
        res_temp_nxt = table_rd;
        state_nxt    = S_OUT;
      end
      S_LO: begin
        lo_nxt    = table_rd;
        rd_en     = 1'b1;
        rd_addr   = seg_r + 1'b1;
        state_nxt = S_HI;
      end
      S_HI: begin
        prod_nxt  = step_diff * frac_s;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        res_temp_nxt = acc[FW +: TW];
        state_nxt    = S_OUT;
      end
      S_REQ: begin
        if (scale_k == '0) begin
          req_nxt   = ati_pkg::ADC_MAX;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          req_nxt   = req_sat;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || res_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= ati_pkg::ST_IDLE;
      cal_idx_r   <= '0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      written_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cal_idx_r   <= cal_idx_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        written_r[cal_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    seg_r        <= seg_nxt;
    lo_r         <= lo_nxt;
    prod_r       <= prod_nxt;
    res_temp_r   <= res_temp_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_temp_r   <= res_temp_r;
      out_status_r <= res_status_r;
      out_req_r    <= req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cal_idx_r] <= cmd_head.temp;
    end
    if (rd_en) begin
      rd_data_r    <= mem[rd_addr];
      rd_written_r <= written_r[rd_addr];
      rd_addr_r    <= rd_addr;
    end
  end

  assign res_valid    = out_valid_r;
  assign temperature  = out_temp_r;
  assign cal_status   = out_status_r;
  assign required_adc = out_req_r;

endmodule

// File: rtl/ati_checker.sv
module ati_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ati_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ati_pkg::TUSER_W-1:0]     out_tuser
);

  localparam int TW = ati_pkg::TEMP_W;
  localparam int AW = ati_pkg::ADC_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Output word changed while stalled.");

  a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ati_pkg::ST_CONV |-> out_tdata[TW-1:0] == '0)
    else $error("Nonzero temperature on a calibration word.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ati_pkg::OUT_TDATA_W-1:TW+AW] == '0)
    else $error("Padding bits of out_tdata are not zero.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid after reset.");

endmodule

bind adc_temperature_interpolator ati_checker u_ati_checker (.*);
